/* hw/rtl/hsv2rgb_pkg.sv */
// ============================================================================
// hsv2rgb_pkg: shared constants and types for the HSV to RGB converter
// Sector codes, scale factors and reciprocal constants used by the pipeline.
// ============================================================================
package hsv2rgb_pkg;

    // field widths
    localparam int unsigned HUE_W  = 13;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned REM_W  = 10;

    // one sector is 60 degrees in sixteenths of a degree
    localparam int unsigned SECTOR_SPAN = 960;
    localparam int unsigned FULL_SCALE  = 255;
    localparam int unsigned DEN         = SECTOR_SPAN * FULL_SCALE;   // 244800
    localparam int unsigned DEN_W       = 18;

    // hue / 960 = (hue >> 6) / 15, and x / 15 = (x * 137) >> 11 for x < 128
    localparam int unsigned DIV15_MUL   = 137;
    localparam int unsigned DIV15_SHIFT = 11;

    // z / 3825 estimate: floor(z * floor(2^32 / 3825) / 2^32), low by at most one
    localparam int unsigned DIV3825     = DEN / 64;
    localparam int unsigned RECIP3825   = 1122867;

    // x / 255 estimate: floor(x * 257 / 2^16), low by at most one
    localparam int unsigned RECIP255    = 257;

    // color wheel sectors
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

endpackage

/* hw/rtl/hsv_to_rgb_converter.sv */
// ============================================================================
// hsv_to_rgb_converter: six-sector HSV to 8-bit RGB pixel converter
// Each pixel passes through the stage 1 to stage 4 registers and the output register.
// Throughput: one pixel per cycle; the whole five-stage pipeline holds
// while the output register is full and not taken.
// Reset clears the stage valid bits only; the data path registers are not reset.
// ============================================================================
module hsv_to_rgb_converter
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue[12:0], saturation[20:13], brightness[28:21]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int unsigned HW = hsv2rgb_pkg::HUE_W;
    localparam int unsigned CW = hsv2rgb_pkg::CHAN_W;
    localparam int unsigned RW = hsv2rgb_pkg::REM_W;
    localparam int unsigned DW = hsv2rgb_pkg::DEN_W;

    // whole pipeline advances together unless the output is blocked
    logic advance;
    assign advance       = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = advance;

    // ------------------------------------------------------------------
    // stage 1: sector and remainder
    // ------------------------------------------------------------------
    logic [HW-1:0]  hue_in;
    logic [CW-1:0]  sat_in;
    logic [CW-1:0]  val_in;
    logic [14:0]    quot_prod;
    logic [3:0]     quot;
    logic [HW-1:0]  quot_span;
    logic [HW-1:0]  rem_full;
    logic [RW-1:0]  rem_next;
    hsv2rgb_pkg::sector_t sector_next;

    assign hue_in = s_axis_tdata[12:0];
    assign sat_in = s_axis_tdata[20:13];
    assign val_in = s_axis_tdata[28:21];

    always_comb
    begin
        quot_prod = 15'({8'd0, hue_in[HW-1:6]} * 15'(hsv2rgb_pkg::DIV15_MUL));
        quot      = quot_prod[hsv2rgb_pkg::DIV15_SHIFT +: 4];
        quot_span = HW'({9'd0, quot} * HW'(hsv2rgb_pkg::SECTOR_SPAN));
        rem_full  = hue_in - quot_span;
        rem_next  = rem_full[RW-1:0];
        // hue past a full turn wraps back to the first sectors
        if (quot >= 4'd6)
        begin
            sector_next = hsv2rgb_pkg::sector_t'(3'(quot - 4'd6));
        end
        else
        begin
            sector_next = hsv2rgb_pkg::sector_t'(quot[2:0]);
        end
    end

    logic                 s1_valid_reg;
    hsv2rgb_pkg::sector_t s1_sector_reg;
    logic [RW-1:0]        s1_rem_reg;
    logic [CW-1:0]        s1_sat_reg;
    logic [CW-1:0]        s1_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sector_reg <= sector_next;
            s1_rem_reg    <= rem_next;
            s1_sat_reg    <= sat_in;
            s1_val_reg    <= val_in;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: saturation products and numerators
    // ------------------------------------------------------------------
    logic [DW-1:0] rem_sat;
    logic [DW-1:0] crem_sat;
    logic [RW-1:0] crem;
    logic [DW-1:0] dq_next;
    logic [DW-1:0] dt_next;
    logic [15:0]   pn_next;

    always_comb
    begin
        crem     = RW'(hsv2rgb_pkg::SECTOR_SPAN) - s1_rem_reg;
        rem_sat  = DW'({8'd0, s1_rem_reg} * {10'd0, s1_sat_reg});
        crem_sat = DW'({8'd0, crem} * {10'd0, s1_sat_reg});
        dq_next  = DW'(hsv2rgb_pkg::DEN) - rem_sat;
        dt_next  = DW'(hsv2rgb_pkg::DEN) - crem_sat;
        pn_next  = 16'({8'd0, s1_val_reg} * {8'd0, CW'(hsv2rgb_pkg::FULL_SCALE) - s1_sat_reg});
    end

    logic                 s2_valid_reg;
    hsv2rgb_pkg::sector_t s2_sector_reg;
    logic [DW-1:0]        s2_dq_reg;
    logic [DW-1:0]        s2_dt_reg;
    logic [15:0]          s2_pn_reg;
    logic [CW-1:0]        s2_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_dq_reg     <= dq_next;
            s2_dt_reg     <= dt_next;
            s2_pn_reg     <= pn_next;
            s2_val_reg    <= s1_val_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: scale numerators by brightness
    // ------------------------------------------------------------------
    logic [25:0] yq_next;
    logic [25:0] yt_next;

    assign yq_next = 26'({18'd0, s2_val_reg} * {8'd0, s2_dq_reg});
    assign yt_next = 26'({18'd0, s2_val_reg} * {8'd0, s2_dt_reg});

    logic                 s3_valid_reg;
    hsv2rgb_pkg::sector_t s3_sector_reg;
    logic [25:0]          s3_yq_reg;
    logic [25:0]          s3_yt_reg;
    logic [15:0]          s3_pn_reg;
    logic [CW-1:0]        s3_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_yq_reg     <= yq_next;
            s3_yt_reg     <= yt_next;
            s3_pn_reg     <= s2_pn_reg;
            s3_val_reg    <= s2_val_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: reciprocal quotient estimates
    // ------------------------------------------------------------------
    logic [19:0] zq_next;
    logic [19:0] zt_next;
    logic [40:0] eq_prod;
    logic [40:0] et_prod;
    logic [23:0] ep_prod;

    always_comb
    begin
        // divide by 64 first, then by 3825
        zq_next = s3_yq_reg[25:6];
        zt_next = s3_yt_reg[25:6];
        eq_prod = 41'({21'd0, zq_next} * 41'(hsv2rgb_pkg::RECIP3825));
        et_prod = 41'({21'd0, zt_next} * 41'(hsv2rgb_pkg::RECIP3825));
        ep_prod = 24'({8'd0, s3_pn_reg} * 24'(hsv2rgb_pkg::RECIP255));
    end

    logic                 s4_valid_reg;
    hsv2rgb_pkg::sector_t s4_sector_reg;
    logic [19:0]          s4_zq_reg;
    logic [19:0]          s4_zt_reg;
    logic [15:0]          s4_pn_reg;
    logic [CW-1:0]        s4_eq_reg;
    logic [CW-1:0]        s4_et_reg;
    logic [CW-1:0]        s4_ep_reg;
    logic [CW-1:0]        s4_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_sector_reg <= s3_sector_reg;
            s4_zq_reg     <= zq_next;
            s4_zt_reg     <= zt_next;
            s4_pn_reg     <= s3_pn_reg;
            s4_eq_reg     <= eq_prod[39:32];
            s4_et_reg     <= et_prod[39:32];
            s4_ep_reg     <= ep_prod[23:16];
            s4_val_reg    <= s3_val_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: estimate correction and sector mux
    // ------------------------------------------------------------------
    logic [19:0]   rq;
    logic [19:0]   rt;
    logic [15:0]   rp;
    logic [CW-1:0] q_fix;
    logic [CW-1:0] t_fix;
    logic [CW-1:0] p_fix;
    logic [CW-1:0] red_next;
    logic [CW-1:0] green_next;
    logic [CW-1:0] blue_next;

    always_comb
    begin
        rq = s4_zq_reg - 20'({12'd0, s4_eq_reg} * 20'(hsv2rgb_pkg::DIV3825));
        rt = s4_zt_reg - 20'({12'd0, s4_et_reg} * 20'(hsv2rgb_pkg::DIV3825));
        rp = s4_pn_reg - 16'({8'd0, s4_ep_reg} * 16'(hsv2rgb_pkg::FULL_SCALE));
        q_fix = (rq >= 20'(hsv2rgb_pkg::DIV3825))    ? s4_eq_reg + 8'd1 : s4_eq_reg;
        t_fix = (rt >= 20'(hsv2rgb_pkg::DIV3825))    ? s4_et_reg + 8'd1 : s4_et_reg;
        p_fix = (rp >= 16'(hsv2rgb_pkg::FULL_SCALE)) ? s4_ep_reg + 8'd1 : s4_ep_reg;
    end

    always_comb
    begin
        unique case (s4_sector_reg)
            hsv2rgb_pkg::SEC_RED_YELLOW:
            begin
                red_next = s4_val_reg; green_next = t_fix;      blue_next = p_fix;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN:
            begin
                red_next = q_fix;      green_next = s4_val_reg; blue_next = p_fix;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN:
            begin
                red_next = p_fix;      green_next = s4_val_reg; blue_next = t_fix;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE:
            begin
                red_next = p_fix;      green_next = q_fix;      blue_next = s4_val_reg;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA:
            begin
                red_next = t_fix;      green_next = p_fix;      blue_next = s4_val_reg;
            end
            hsv2rgb_pkg::SEC_MAGENTA_RED:
            begin
                red_next = s4_val_reg; green_next = p_fix;      blue_next = q_fix;
            end
            default:
            begin
                red_next = s4_val_reg; green_next = p_fix;      blue_next = q_fix;
            end
        endcase
    end

    // output register
    logic          out_valid_reg;
    logic [CW-1:0] red_reg;
    logic [CW-1:0] green_reg;
    logic [CW-1:0] blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {blue_reg, green_reg, red_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_rem_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_rem_reg < RW'(hsv2rgb_pkg::SECTOR_SPAN)))
        else $error("sector remainder out of range");

    a_num_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_dq_reg <= DW'(hsv2rgb_pkg::DEN)
                          && s2_dt_reg <= DW'(hsv2rgb_pkg::DEN)))
        else $error("numerator exceeds full-scale denominator");

    a_corr_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (rq < 20'(2 * hsv2rgb_pkg::DIV3825)
                          && rt < 20'(2 * hsv2rgb_pkg::DIV3825)
                          && rp < 16'(2 * hsv2rgb_pkg::FULL_SCALE)))
        else $error("reciprocal estimate off by more than one");

    a_terms_below_value: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (q_fix <= s4_val_reg && t_fix <= s4_val_reg
                          && p_fix <= s4_val_reg))
        else $error("channel term exceeds brightness");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && m_axis_tvalid
             && $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg})))
        else $error("pipeline moved during output stall");

endmodule

/* tb/sv/tb.sv */
// ============================================================================
// tb: self-checking testbench for hsv_to_rgb_converter
// Drives HSV pixels into the input stream and checks each RGB result against
// an integer six-sector prediction, under several patterns of source idling
// and sink backpressure.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one pixel with its expected color
    typedef struct {
        logic [12:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_t;

    // exact integer six-sector conversion, hue wraps modulo six sectors
    function automatic pixel_t convert_pixel(logic [12:0] hue, logic [7:0] sat,
                                             logic [7:0] val);
        int unsigned v;
        int unsigned rem;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        hsv2rgb_pkg::sector_t sec;
        pixel_t      px;
        v   = val;
        rem = hue % hsv2rgb_pkg::SECTOR_SPAN;
        sec = hsv2rgb_pkg::sector_t'((hue / hsv2rgb_pkg::SECTOR_SPAN) % 6);
        p   = v * (hsv2rgb_pkg::FULL_SCALE - sat) / hsv2rgb_pkg::FULL_SCALE;
        q   = v * (hsv2rgb_pkg::DEN - rem * sat) / hsv2rgb_pkg::DEN;
        t   = v * (hsv2rgb_pkg::DEN - (hsv2rgb_pkg::SECTOR_SPAN - rem) * sat)
              / hsv2rgb_pkg::DEN;
        px.hue = hue;
        px.sat = sat;
        px.val = val;
        unique case (sec)
            hsv2rgb_pkg::SEC_RED_YELLOW:
            begin
                px.red = 8'(v); px.green = 8'(t); px.blue = 8'(p);
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN:
            begin
                px.red = 8'(q); px.green = 8'(v); px.blue = 8'(p);
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN:
            begin
                px.red = 8'(p); px.green = 8'(v); px.blue = 8'(t);
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE:
            begin
                px.red = 8'(p); px.green = 8'(q); px.blue = 8'(v);
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA:
            begin
                px.red = 8'(t); px.green = 8'(p); px.blue = 8'(v);
            end
            default:
            begin
                px.red = 8'(v); px.green = 8'(p); px.blue = 8'(q);
            end
        endcase
        return px;
    endfunction

    // holds expected pixels in transfer order and checks results against them
    class pixel_scoreboard;
        pixel_t      pending_pixels[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_pixel(logic [12:0] hue, logic [7:0] sat, logic [7:0] val);
            pending_pixels.insert(pending_pixels.size(), convert_pixel(hue, sat, val));
        endfunction

        function int unsigned pending();
            return pending_pixels.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_pixel(logic [23:0] data);
            pixel_t px;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %06h", data));
                return;
            end
            px = pending_pixels.pop_front();
            if (data[7:0] !== px.red)
                report_mismatch($sformatf("hsv %0d/%0d/%0d red %0d, want %0d",
                                          px.hue, px.sat, px.val, data[7:0], px.red));
            if (data[15:8] !== px.green)
                report_mismatch($sformatf("hsv %0d/%0d/%0d green %0d, want %0d",
                                          px.hue, px.sat, px.val, data[15:8], px.green));
            if (data[23:16] !== px.blue)
                report_mismatch($sformatf("hsv %0d/%0d/%0d blue %0d, want %0d",
                                          px.hue, px.sat, px.val, data[23:16], px.blue));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    int unsigned     source_idle_pct;
    int unsigned     sink_stall_pct;
    pixel_scoreboard sb;

    hsv_to_rgb_converter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // one pixel transfer on the input stream, with a random idle gap first
    task send_pixel(logic [12:0] hue, logic [7:0] sat, logic [7:0] val);
        while ($urandom_range(99) < source_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, sat, hue};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel(hue, sat, val);
    endtask

    // output side: check each transfer, then pick the next ready value
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // stimulus
    initial
    begin
        logic [12:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        int unsigned idle_pcts[4];
        int unsigned stall_pcts[4];

        idle_pcts  = '{0, 46, 0, 15};
        stall_pcts = '{0, 0, 46, 15};
        sb = new();
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sector edges, hue wrap past a full turn, zero saturation and value
        send_pixel(13'd0,    8'd255, 8'd255);
        send_pixel(13'd959,  8'd255, 8'd255);
        send_pixel(13'd960,  8'd255, 8'd255);
        send_pixel(13'd1919, 8'd200, 8'd255);
        send_pixel(13'd1920, 8'd255, 8'd128);
        send_pixel(13'd2880, 8'd255, 8'd255);
        send_pixel(13'd3840, 8'd100, 8'd200);
        send_pixel(13'd4800, 8'd255, 8'd255);
        send_pixel(13'd5759, 8'd255, 8'd255);
        send_pixel(13'd5760, 8'd255, 8'd255);
        send_pixel(13'd6720, 8'd128, 8'd77);
        send_pixel(13'd7680, 8'd255, 8'd255);
        send_pixel(13'd8191, 8'd255, 8'd255);
        send_pixel(13'd8191, 8'd0,   8'd255);
        send_pixel(13'd2000, 8'd0,   8'd200);
        send_pixel(13'd3000, 8'd255, 8'd0);
        send_pixel(13'd0,    8'd0,   8'd0);
        send_pixel(13'd4321, 8'd1,   8'd254);
        send_pixel(13'd480,  8'd128, 8'd128);
        send_pixel(13'd5000, 8'd255, 8'd1);
        send_pixel(13'd1440, 8'd170, 8'd85);

        // random pixels under each idle and stall pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            source_idle_pct = idle_pcts[ph];
            sink_stall_pct  = stall_pcts[ph];
            for (int n = 0; n < 325; n++)
            begin
                case ($urandom_range(9))
                    0: hue = 13'($urandom_range(8191, 5760));
                    1: hue = 13'($urandom_range(5) * 960
                                 + ($urandom_range(1) ? $urandom_range(3)
                                                      : $urandom_range(959, 956)));
                    default: hue = 13'($urandom_range(5759));
                endcase
                case ($urandom_range(9))
                    0: sat = 8'd0;
                    1: sat = 8'd255;
                    default: sat = 8'($urandom_range(255));
                endcase
                case ($urandom_range(9))
                    0: val = 8'd0;
                    1: val = 8'd255;
                    default: val = 8'($urandom_range(255));
                endcase
                send_pixel(hue, sat, val);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow for the pipeline depth
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv_to_rgb_converter.sv
tb/sv/tb.sv
